[rtl/core/s5dfr_pkg.sv]
// shared types and codes for the socks5 reply checker and length deframer
package s5dfr_pkg;

  typedef enum logic [2:0] {
    PH_CLOSED,
    PH_METHOD,
    PH_AUTH,
    PH_CONNECT,
    PH_HEADER,
    PH_BODY
  } phase_t;

  localparam logic [2:0] KIND_PAYLOAD = 3'd0;
  localparam logic [2:0] KIND_EMPTY   = 3'd1;
  localparam logic [2:0] KIND_GREET   = 3'd2;
  localparam logic [2:0] KIND_AUTH    = 3'd3;
  localparam logic [2:0] KIND_CONNECT = 3'd4;
  localparam logic [2:0] KIND_UP      = 3'd5;
  localparam logic [2:0] KIND_FAIL    = 3'd6;

  localparam logic [2:0] FAIL_METHOD    = 3'd0;
  localparam logic [2:0] FAIL_AUTH      = 3'd1;
  localparam logic [2:0] FAIL_ADDR_TYPE = 3'd2;
  localparam logic [2:0] FAIL_CONNECT   = 3'd3;
  localparam logic [2:0] FAIL_LENGTH    = 3'd4;
  localparam logic [2:0] FAIL_SERVER    = 3'd5;

  localparam logic [7:0] METH_NO_AUTH   = 8'h00;
  localparam logic [7:0] METH_USER_PASS = 8'h02;
  localparam logic [7:0] AUTH_OK        = 8'h00;
  localparam logic [7:0] ATYP_IPV4      = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN    = 8'h03;
  localparam logic [7:0] ATYP_IPV6      = 8'h04;

  localparam logic [8:0] NEED_IPV4   = 9'd10;
  localparam logic [8:0] NEED_IPV6   = 9'd22;
  localparam logic [8:0] NEED_DOMAIN = 9'd7;

  localparam logic        CFG_USE_PROXY = 1'b0;
  localparam logic        CFG_MAX_LEN   = 1'b1;
  localparam logic [30:0] MAX_LEN_RESET = 31'd16777216;

  localparam int CNT_W = 31;

endpackage

[rtl/core/socks5_reply_and_length_deframer.sv]
// socks5 reply checker and length-prefixed frame deframer for a client receive stream
//
// Input stream s_axis: one word per received byte; tuser[0] set marks a start of
// session (connection up), tdata is the received byte otherwise.
// Output stream m_axis: at most one word per input word. tuser is the result kind,
// tlast marks the final byte of a frame body, tdata carries the payload byte, the
// failure reason and the failure detail.
// Configuration: cfg_valid/cfg_ready write port, index 0 use_proxy (sampled at
// session start), index 1 max_packet_len (used live). cfg_ready is always high.
// The result of a word accepted at one edge is valid in the output register right
// after it. Throughput is one word per cycle while the receiver takes results; every
// decision is a byte compare or one 31-bit count/length compare between the state
// registers and the output register.
// A stalled receiver holds the output register; s_axis_tready drops only while
// that register is full and not being taken, so a new word is taken in the same
// cycle the held one leaves.
// Reset closes the session, clears all counters and restores the register resets
// (use_proxy 0, max_packet_len 16777216); data bytes while closed are dropped.
module socks5_reply_and_length_deframer
  import s5dfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  input  logic [0:0]  s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // data_byte, fail_reason, detail, zero pad
  output logic        m_axis_tlast,   // last
  output logic [2:0]  m_axis_tuser,   // kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  logic              use_proxy;
  logic [30:0]       max_len;
  phase_t            phase, phase_next;
  logic [CNT_W-1:0]  byte_count, byte_count_next;
  logic [31:0]       frame_length, frame_length_next;
  logic [7:0]        reply_code, reply_code_next;
  logic [8:0]        reply_need, reply_need_next;
  logic [31:0]       error_word, error_word_next;

  logic              res_valid;
  logic [2:0]        res_kind;
  logic [7:0]        res_data;
  logic              res_last;
  logic [2:0]        res_reason;
  logic [31:0]       res_detail;

  logic [2:0]        out_kind;
  logic [7:0]        out_data;
  logic              out_last;
  logic [2:0]        out_reason;
  logic [31:0]       out_detail;

  logic              take, is_start;
  logic [7:0]        b;
  logic [CNT_W-1:0]  bc_inc;
  logic              bc_is0, bc_is1, bc_is3, bc_is4;
  logic [31:0]       b_shift;
  logic [31:0]       len_full, err_full;
  logic              len_bad;
  logic [8:0]        need_decode, need_upd;
  logic              addr_bad, conn_done, body_end;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign is_start      = s_axis_tuser[0];
  assign b             = s_axis_tdata;

  assign bc_inc  = byte_count + CNT_W'(1);
  assign bc_is0  = byte_count == CNT_W'(0);
  assign bc_is1  = byte_count == CNT_W'(1);
  assign bc_is3  = byte_count == CNT_W'(3);
  assign bc_is4  = byte_count == CNT_W'(4);
  assign b_shift = {24'd0, b} << {byte_count[1:0], 3'b000};

  assign len_full = {b, frame_length[23:0]};
  assign err_full = {b, error_word[23:0]};
  assign len_bad  = len_full[31] || (len_full[30:0] > max_len);
  assign body_end = bc_inc >= frame_length[30:0];

  always_comb begin
    case (b)
      ATYP_IPV4:   need_decode = NEED_IPV4;
      ATYP_IPV6:   need_decode = NEED_IPV6;
      ATYP_DOMAIN: need_decode = NEED_DOMAIN;
      default:     need_decode = {1'b1, b};
    endcase
  end

  assign need_upd  = (bc_is4 && reply_need == NEED_DOMAIN) ? NEED_DOMAIN + {1'b0, b}
                                                            : reply_need;
  assign addr_bad  = bc_is4 && reply_need[8];
  assign conn_done = (bc_inc >= CNT_W'(5)) && (bc_inc == CNT_W'(need_upd));

  // next state
  always_comb begin
    phase_next = phase;
    if (take) begin
      if (is_start) begin
        phase_next = use_proxy ? PH_METHOD : PH_HEADER;
      end else begin
        case (phase)
          PH_METHOD: begin
            if (!bc_is0) begin
              if (b == METH_USER_PASS) phase_next = PH_AUTH;
              else if (b == METH_NO_AUTH) phase_next = PH_CONNECT;
              else phase_next = PH_CLOSED;
            end
          end
          PH_AUTH: begin
            if (!bc_is0) phase_next = (b == AUTH_OK) ? PH_CONNECT : PH_CLOSED;
          end
          PH_CONNECT: begin
            if (addr_bad) phase_next = PH_CLOSED;
            else if (conn_done) phase_next = (reply_code != 8'd0) ? PH_CLOSED : PH_HEADER;
          end
          PH_HEADER: begin
            if (bc_is3) begin
              if (len_bad) phase_next = PH_CLOSED;
              else if (len_full == 32'd0) phase_next = PH_HEADER;
              else phase_next = PH_BODY;
            end
          end
          PH_BODY: begin
            if (frame_length == 32'd4) begin
              if (bc_is3) phase_next = PH_CLOSED;
            end else if (body_end) begin
              phase_next = PH_HEADER;
            end
          end
          default: phase_next = phase;
        endcase
      end
    end
  end

  // result word
  always_comb begin
    res_valid  = 1'b0;
    res_kind   = KIND_PAYLOAD;
    res_data   = 8'd0;
    res_last   = 1'b0;
    res_reason = 3'd0;
    res_detail = 32'd0;
    if (is_start) begin
      res_valid = 1'b1;
      res_kind  = use_proxy ? KIND_GREET : KIND_UP;
    end else begin
      case (phase)
        PH_METHOD: begin
          if (!bc_is0) begin
            res_valid = 1'b1;
            if (b == METH_USER_PASS) begin
              res_kind = KIND_AUTH;
            end else if (b == METH_NO_AUTH) begin
              res_kind = KIND_CONNECT;
            end else begin
              res_kind   = KIND_FAIL;
              res_reason = FAIL_METHOD;
              res_detail = {24'd0, b};
            end
          end
        end
        PH_AUTH: begin
          if (!bc_is0) begin
            res_valid = 1'b1;
            if (b == AUTH_OK) begin
              res_kind = KIND_CONNECT;
            end else begin
              res_kind   = KIND_FAIL;
              res_reason = FAIL_AUTH;
              res_detail = {24'd0, b};
            end
          end
        end
        PH_CONNECT: begin
          if (addr_bad) begin
            res_valid  = 1'b1;
            res_kind   = KIND_FAIL;
            res_reason = FAIL_ADDR_TYPE;
            res_detail = {24'd0, reply_need[7:0]};
          end else if (conn_done) begin
            res_valid = 1'b1;
            if (reply_code != 8'd0) begin
              res_kind   = KIND_FAIL;
              res_reason = FAIL_CONNECT;
              res_detail = {24'd0, reply_code};
            end else begin
              res_kind = KIND_UP;
            end
          end
        end
        PH_HEADER: begin
          if (bc_is3) begin
            if (len_bad) begin
              res_valid  = 1'b1;
              res_kind   = KIND_FAIL;
              res_reason = FAIL_LENGTH;
              res_detail = len_full;
            end else if (len_full == 32'd0) begin
              res_valid = 1'b1;
              res_kind  = KIND_EMPTY;
            end
          end
        end
        PH_BODY: begin
          if (frame_length == 32'd4) begin
            if (bc_is3) begin
              res_valid  = 1'b1;
              res_kind   = KIND_FAIL;
              res_reason = FAIL_SERVER;
              res_detail = err_full;
            end
          end else begin
            res_valid = 1'b1;
            res_kind  = KIND_PAYLOAD;
            res_data  = b;
            res_last  = body_end;
          end
        end
        default: res_valid = 1'b0;
      endcase
    end
  end

  // session counters and assembly registers
  always_comb begin
    byte_count_next   = byte_count;
    frame_length_next = frame_length;
    reply_code_next   = reply_code;
    reply_need_next   = reply_need;
    error_word_next   = error_word;
    if (take) begin
      if (is_start || phase_next != phase_t'(phase) && phase_next != PH_BODY
          || phase == PH_BODY && phase_next == PH_HEADER) begin
        byte_count_next   = '0;
        frame_length_next = '0;
        reply_code_next   = '0;
        reply_need_next   = '0;
        error_word_next   = '0;
      end else begin
        case (phase)
          PH_METHOD, PH_AUTH: begin
            byte_count_next = CNT_W'(1);
          end
          PH_CONNECT: begin
            byte_count_next = bc_inc;
            if (bc_is1) reply_code_next = b;
            reply_need_next = bc_is3 ? need_decode : need_upd;
          end
          PH_HEADER: begin
            byte_count_next   = bc_is3 ? CNT_W'(0) : bc_inc;
            frame_length_next = frame_length | b_shift;
          end
          PH_BODY: begin
            byte_count_next = bc_inc;
            if (frame_length == 32'd4) error_word_next = error_word | b_shift;
          end
          default: byte_count_next = byte_count;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      use_proxy     <= 1'b0;
      max_len       <= MAX_LEN_RESET;
      phase         <= PH_CLOSED;
      byte_count    <= '0;
      frame_length  <= '0;
      reply_code    <= '0;
      reply_need    <= '0;
      error_word    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_USE_PROXY: use_proxy <= cfg_data[0];
          CFG_MAX_LEN:   max_len   <= cfg_data;
          default:       use_proxy <= use_proxy;
        endcase
      end
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      frame_length <= frame_length_next;
      reply_code   <= reply_code_next;
      reply_need   <= reply_need_next;
      error_word   <= error_word_next;
      if (s_axis_tready) m_axis_tvalid <= take && res_valid;
    end
  end

  // output register, loaded whenever it is free
  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      out_kind   <= res_kind;
      out_data   <= res_data;
      out_last   <= res_last;
      out_reason <= res_reason;
      out_detail <= res_detail;
    end
  end

  assign m_axis_tuser = out_kind;
  assign m_axis_tlast = out_last;
  assign m_axis_tdata = {5'd0, out_detail, out_reason, out_data};

endmodule

[sim/tb_socks5_reply_and_length_deframer.sv]
// testbench for the socks5 reply checker and length-prefixed frame deframer
`timescale 1ns / 1ps

module tb_socks5_reply_and_length_deframer;
  import s5dfr_pkg::*;

  localparam int ITEMS_PER_PHASE = 170;
  localparam int CYCLE_LIMIT     = 500000;

  typedef struct {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic        last;
    logic [2:0]  reason;
    logic [31:0] detail;
  } reply_word_t;

  class deframer_scoreboard;
    logic        use_proxy;
    logic [30:0] max_len;
    phase_t      phase;
    logic [31:0] count;
    logic [31:0] flen;
    logic [31:0] err_word;
    logic [7:0]  rcode;
    logic [8:0]  need;
    reply_word_t reply_q[$];
    int          errors;
    int          n_in;
    int          n_ignored;
    int          n_results;
    int          kind_seen[8];

    function new();
      use_proxy = 1'b0;
      max_len   = MAX_LEN_RESET;
      phase     = PH_CLOSED;
      clear();
      errors    = 0;
      n_in      = 0;
      n_ignored = 0;
      n_results = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function void clear();
      count    = '0;
      flen     = '0;
      err_word = '0;
      rcode    = '0;
      need     = '0;
    endfunction

    function void enter(phase_t p);
      phase = p;
      clear();
    endfunction

    function void push(logic [2:0] kind, logic [7:0] data, logic last,
                       logic [2:0] reason, logic [31:0] detail);
      reply_word_t w;
      w.kind   = kind;
      w.data   = data;
      w.last   = last;
      w.reason = reason;
      w.detail = detail;
      reply_q.push_back(w);
    endfunction

    function void fail(logic [2:0] reason, logic [31:0] detail);
      enter(PH_CLOSED);
      push(KIND_FAIL, 8'h00, 1'b0, reason, detail);
    endfunction

    function void set_reg(logic [0:0] idx, logic [30:0] data);
      if (idx == CFG_USE_PROXY) use_proxy = data[0];
      else max_len = data;
    endfunction

    function int active_items();
      return n_in - n_ignored;
    endfunction

    function void note_input(logic act, logic [7:0] b);
      n_in++;
      if (act) begin
        if (use_proxy) begin
          enter(PH_METHOD);
          push(KIND_GREET, 8'h00, 1'b0, 3'd0, 32'd0);
        end else begin
          enter(PH_HEADER);
          push(KIND_UP, 8'h00, 1'b0, 3'd0, 32'd0);
        end
        return;
      end
      case (phase)
        PH_METHOD, PH_AUTH: begin
          if (count == 0) begin
            count = 1;
          end else if (phase == PH_METHOD) begin
            if (b == METH_USER_PASS) begin
              enter(PH_AUTH);
              push(KIND_AUTH, 8'h00, 1'b0, 3'd0, 32'd0);
            end else if (b == METH_NO_AUTH) begin
              enter(PH_CONNECT);
              push(KIND_CONNECT, 8'h00, 1'b0, 3'd0, 32'd0);
            end else begin
              fail(FAIL_METHOD, {24'd0, b});
            end
          end else if (b != AUTH_OK) begin
            fail(FAIL_AUTH, {24'd0, b});
          end else begin
            enter(PH_CONNECT);
            push(KIND_CONNECT, 8'h00, 1'b0, 3'd0, 32'd0);
          end
        end
        PH_CONNECT: begin
          if (count == 1) rcode = b;
          if (count == 3) begin
            case (b)
              ATYP_IPV4:   need = NEED_IPV4;
              ATYP_IPV6:   need = NEED_IPV6;
              ATYP_DOMAIN: need = NEED_DOMAIN;
              default:     need = {1'b1, b};
            endcase
          end
          // unknown address type is flagged on the byte after it
          if (count == 4 && need[8]) begin
            fail(FAIL_ADDR_TYPE, {24'd0, need[7:0]});
            return;
          end
          if (count == 4 && need == NEED_DOMAIN) need = NEED_DOMAIN + {1'b0, b};
          count++;
          if (count >= 5 && count == {23'd0, need}) begin
            if (rcode != 8'h00) begin
              fail(FAIL_CONNECT, {24'd0, rcode});
            end else begin
              enter(PH_HEADER);
              push(KIND_UP, 8'h00, 1'b0, 3'd0, 32'd0);
            end
          end
        end
        PH_HEADER: begin
          flen = flen | ({24'd0, b} << (8 * count[1:0]));
          count++;
          if (count == 4) begin
            count = 0;
            if (flen[31] || flen > {1'b0, max_len}) fail(FAIL_LENGTH, flen);
            else if (flen == 0) push(KIND_EMPTY, 8'h00, 1'b0, 3'd0, 32'd0);
            else phase = PH_BODY;
          end
        end
        PH_BODY: begin
          count++;
          if (flen == 4) begin
            err_word = err_word | ({24'd0, b} << (8 * ((count - 1) & 3)));
            if (count >= 4) fail(FAIL_SERVER, err_word);
          end else if (count >= flen) begin
            enter(PH_HEADER);
            push(KIND_PAYLOAD, b, 1'b1, 3'd0, 32'd0);
          end else begin
            push(KIND_PAYLOAD, b, 1'b0, 3'd0, 32'd0);
          end
        end
        default: n_ignored++;
      endcase
    endfunction

    function void check_result(logic [2:0] kind, logic [47:0] tdata, logic last);
      reply_word_t w;
      logic [7:0]  data;
      logic [2:0]  reason;
      logic [31:0] detail;
      data   = tdata[7:0];
      reason = tdata[10:8];
      detail = tdata[42:11];
      n_results++;
      if (kind < 7) kind_seen[kind]++;
      if (reply_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected word kind %0d data %02h last %0d reason %0d detail %08h",
                   $realtime, kind, data, last, reason, detail);
        return;
      end
      w = reply_q.pop_front();
      if (kind !== w.kind || data !== w.data || last !== w.last ||
          reason !== w.reason || detail !== w.detail) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: mismatch exp kind %0d data %02h last %0d reason %0d detail %08h",
                   $realtime, w.kind, w.data, w.last, w.reason, w.detail);
          $display("%0t:          got kind %0d data %02h last %0d reason %0d detail %08h",
                   $realtime, kind, data, last, reason, detail);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [2:0]  m_axis_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [30:0] cfg_data;

  deframer_scoreboard sb;
  bit src_calm;
  bit sink_calm;
  int sink_hold;
  int cycles;

  socks5_reply_and_length_deframer i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver side: random stalls, mostly short
  always @(posedge clk) begin
    if (sink_calm) begin
      m_axis_tready <= 1'b1;
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
    end else begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        sink_hold <= (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
  end

  function automatic int pick_gap();
    int r;
    if (src_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_word(input logic act, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_input(act, b);
  endtask

  // data word, now and then preceded by a start that breaks the session
  task automatic send_data(input logic [7:0] b);
    if ($urandom_range(0, 99) < 1) send_word(1'b1, 8'($urandom_range(0, 255)));
    send_word(1'b0, b);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.reply_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [30:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_length(input logic [31:0] len);
    for (int k = 0; k < 4; k++) send_data(len[8*k +: 8]);
  endtask

  function automatic logic [31:0] pick_len(logic [30:0] maxl);
    int r;
    logic [31:0] len;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'd0;
    if (r < 20) return 32'd4;
    if (r < 23) return 32'hFFFF_FFFF;
    if (r < 26) return {1'b1, 31'($urandom())};
    if (r < 32 && maxl != 31'h7FFF_FFFF) return {1'b0, maxl} + 32'($urandom_range(1, 4));
    len = (r < 92) ? $urandom_range(1, 12) : $urandom_range(13, 64);
    if (len > {1'b0, maxl}) len = {1'b0, maxl};
    return len;
  endfunction

  task automatic run_session();
    int r;
    int nframes;
    logic [7:0] atyp;
    src_calm  = ($urandom_range(0, 99) < 15);
    sink_calm = ($urandom_range(0, 99) < 15);
    if (sb.phase == PH_CLOSED)
      repeat ($urandom_range(0, 2)) send_word(1'b0, 8'($urandom_range(0, 255)));
    send_word(1'b1, 8'($urandom_range(0, 255)));
    if (sb.phase == PH_METHOD) begin
      send_data(8'($urandom_range(0, 255)));
      r = $urandom_range(0, 99);
      send_data(r < 55 ? METH_NO_AUTH : r < 88 ? METH_USER_PASS : 8'($urandom_range(0, 255)));
      if (sb.phase == PH_AUTH) begin
        send_data(8'($urandom_range(0, 255)));
        send_data($urandom_range(0, 99) < 85 ? AUTH_OK : 8'($urandom_range(0, 255)));
      end
      if (sb.phase == PH_CONNECT) begin
        send_data(8'($urandom_range(0, 255)));
        send_data($urandom_range(0, 99) < 85 ? 8'h00 : 8'($urandom_range(0, 255)));
        send_data(8'($urandom_range(0, 255)));
        r = $urandom_range(0, 99);
        atyp = r < 30 ? ATYP_IPV4 : r < 55 ? ATYP_IPV6 : r < 85 ? ATYP_DOMAIN :
               8'($urandom_range(0, 255));
        send_data(atyp);
        if (sb.phase == PH_CONNECT && atyp == ATYP_DOMAIN)
          send_data($urandom_range(0, 99) < 90 ? 8'($urandom_range(0, 16)) :
                    8'($urandom_range(0, 255)));
        while (sb.phase == PH_CONNECT) send_data(8'($urandom_range(0, 255)));
      end
    end
    nframes = $urandom_range(1, 6);
    for (int i = 0; i < nframes; i++) begin
      if (sb.phase != PH_HEADER) break;
      send_length(pick_len(sb.max_len));
      while (sb.phase == PH_BODY) send_data(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_phase(input logic proxy, input logic [30:0] maxl, input bit write);
    int target;
    if (write) begin
      drain();
      write_reg(CFG_USE_PROXY, {30'd0, proxy});
      write_reg(CFG_MAX_LEN, maxl);
    end
    target = sb.active_items() + ITEMS_PER_PHASE;
    while (sb.active_items() < target) run_session();
  endtask

  initial begin
    sb = new();
    cycles        = 0;
    sink_hold     = 0;
    src_calm      = 1'b0;
    sink_calm     = 1'b0;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tuser  <= 1'b0;
    m_axis_tready <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_USE_PROXY;
    cfg_data      <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, register reset values
    send_word(1'b0, 8'hA5);
    send_word(1'b1, 8'h00);
    send_length(32'd0);
    send_length(32'd1);
    send_word(1'b0, 8'hFF);
    send_length(32'h8000_0000);
    send_word(1'b0, 8'hFF);
    send_word(1'b1, 8'hFF);
    send_length(32'h0100_0001);

    run_phase(1'b0, MAX_LEN_RESET, 1'b0);
    run_phase(1'b1, MAX_LEN_RESET, 1'b1);
    run_phase(1'b1, 31'd0, 1'b1);
    run_phase(1'b0, 31'h7FFF_FFFF, 1'b1);
    run_phase(1'b1, 31'h7FFF_FFFF, 1'b1);
    run_phase(1'b1, 31'd6, 1'b1);
    run_phase(1'b0, 31'd3, 1'b1);
    run_phase(1'b1, 31'($urandom_range(4, 40)), 1'b1);
    drain();
    repeat (6) @(posedge clk);

    if (sb.reply_q.size() != 0) begin
      $display("%0d expected words never arrived", sb.reply_q.size());
      sb.errors += sb.reply_q.size();
    end
    $display("run covered %0d input words (%0d dropped while closed), %0d results checked",
             sb.n_in, sb.n_ignored, sb.n_results);
    $display("kinds: payload %0d empty %0d greet %0d auth %0d connect %0d up %0d fail %0d",
             sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3],
             sb.kind_seen[4], sb.kind_seen[5], sb.kind_seen[6]);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/s5dfr_pkg.sv
rtl/core/socks5_reply_and_length_deframer.sv
sim/tb_socks5_reply_and_length_deframer.sv
